FILE: rtl/sacl_pkg.sv
// sacl_pkg: shared types and constants of the set-associative tag lookup
// holds the config word layout, mode codes, register indexes and the fsm state type
// no dependencies
package sacl_pkg;

  // address and tag widths of the access word
  localparam int ADDR_W = 32;
  localparam int TAG_W  = 32;

  // configuration port layout
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 5;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_INDEX_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_WIDTH = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WAYS_LOG2    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_REPL_MODE    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_WRITE_MODE   = 3'd4;

  // replacement modes (code three acts as random)
  localparam logic [1:0] MODE_LRU  = 2'd0;
  localparam logic [1:0] MODE_FIFO = 2'd1;
  localparam logic [1:0] MODE_RAND = 2'd2;

  // write policies
  localparam logic WM_WB = 1'b0;
  localparam logic WM_WT = 1'b1;

  // victim lfsr
  localparam logic [15:0] LFSR_SEED = 16'hACE1;
  localparam logic [15:0] LFSR_TAPS = 16'hB400;

  // configuration registers as one group
  typedef struct packed {
    logic [3:0] index_width;
    logic [4:0] offset_width;
    logic [1:0] ways_log2;
    logic [1:0] repl_mode;
    logic       write_mode;
  } cfg_t;

  // outcome of one lookup, from the update logic to the control
  typedef struct packed {
    logic hit;
    logic wr_en;
    logic lfsr_adv;
  } upd_t;

  typedef enum logic {
    ST_IDLE,
    ST_LOOK
  } state_t;

endpackage

FILE: rtl/set_assoc_cache_lookup.sv
// set_assoc_cache_lookup: top level of the set-associative cache tag store
// depends on sacl_pkg, sacl_addr_split, sacl_tag_mem and sacl_update
//
// channel  dir  signals                                  payload
// s_*      in   s_tvalid s_tready s_tuser s_tdata[31:0]  op (tuser), address
// m_*      out  m_tvalid m_tready m_tdata[47:0]          hit, set, tag_value
// cfg_*    in   cfg_valid cfg_ready cfg_index            cfg_data
//
// each word is handled in order: on accept its set row is read from the tag memory,
// then in ST_LOOK all ways are compared, the row written back and the output register loaded.
// a result held by m_tready keeps the block in the compare cycle until the
// output register frees. reset is synchronous; row valid flops mark every
// set empty at once, so there is no clearing pass. cfg_ready is always high.
module set_assoc_cache_lookup import sacl_pkg::*; #(
  parameter int MAX_SETS = 256,
  parameter int MAX_WAYS = 8
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic                  s_tuser,   // [0] op
  input  logic [31:0]           s_tdata,   // [31:0] address
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [47:0]           m_tdata,   // [0] hit, [8:1] set, [40:9] tag_value, rest zero
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int SET_LOG2 = $clog2(MAX_SETS + 1) - 1;
  localparam int SET_AW   = (SET_LOG2 > 0) ? SET_LOG2 : 1;
  localparam int DEPTH    = 1 << SET_LOG2;
  localparam int WAY_LOG2 = $clog2(MAX_WAYS + 1) - 1;
  localparam int WAY_USE  = (WAY_LOG2 < 3) ? WAY_LOG2 : 3;
  localparam int NWAY     = 1 << WAY_USE;

  cfg_t                       cfg;
  state_t                     state, state_next;
  logic [15:0]                lfsr;
  logic [15:0]                lfsr_next;
  logic                       is_write;
  logic [SET_AW-1:0]          set_q;
  logic [TAG_W-1:0]           tag_q;
  logic [SET_AW-1:0]          in_set;
  logic [TAG_W-1:0]           in_tag;
  logic                       in_fire;
  logic                       out_load;
  logic                       mem_wr;
  logic [NWAY-1:0]            rd_vld;
  logic [NWAY-1:0][TAG_W-1:0] rd_tags;
  logic [NWAY-1:0]            new_vld;
  logic [NWAY-1:0][TAG_W-1:0] new_tags;
  upd_t                       upd;
  logic [SET_AW+7:0]          set_ext;

  // configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.index_width  <= 4'd6;
      cfg.offset_width <= 5'd4;
      cfg.ways_log2    <= 2'd2;
      cfg.repl_mode    <= MODE_LRU;
      cfg.write_mode   <= WM_WB;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_INDEX_WIDTH:  cfg.index_width  <= cfg_data[3:0];
        REG_OFFSET_WIDTH: cfg.offset_width <= cfg_data[4:0];
        REG_WAYS_LOG2:    cfg.ways_log2    <= cfg_data[1:0];
        REG_REPL_MODE:    cfg.repl_mode    <= cfg_data[1:0];
        REG_WRITE_MODE:   cfg.write_mode   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // address split of the incoming word
  sacl_addr_split #(
    .SET_LOG2 (SET_LOG2),
    .SET_AW   (SET_AW)
  ) u_split (
    .address (s_tdata),
    .cfg     (cfg),
    .set_idx (in_set),
    .tag     (in_tag)
  );

  // tag memory, read on accept, written back in the compare cycle
  sacl_tag_mem #(
    .DEPTH  (DEPTH),
    .SET_AW (SET_AW),
    .NWAY   (NWAY)
  ) u_mem (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (in_fire),
    .rd_addr (in_set),
    .wr_en   (mem_wr),
    .wr_addr (set_q),
    .wr_vld  (new_vld),
    .wr_tags (new_tags),
    .rd_vld  (rd_vld),
    .rd_tags (rd_tags)
  );

  // compare and replacement
  sacl_update #(
    .WAY_USE (WAY_USE),
    .NWAY    (NWAY)
  ) u_upd (
    .cfg       (cfg),
    .is_write  (is_write),
    .tag       (tag_q),
    .lfsr      (lfsr),
    .old_vld   (rd_vld),
    .old_tags  (rd_tags),
    .new_vld   (new_vld),
    .new_tags  (new_tags),
    .lfsr_next (lfsr_next),
    .upd       (upd)
  );

  // control state machine
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    s_tready   = 1'b0;
    out_load   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          state_next = ST_LOOK;
        end
      end
      ST_LOOK: begin
        if (!m_tvalid || m_tready) begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  assign in_fire = s_tvalid && s_tready;
  assign mem_wr  = out_load && upd.wr_en;

  // word held across the lookup
  always_ff @(posedge clk) begin
    if (in_fire) begin
      is_write <= s_tuser;
      set_q    <= in_set;
      tag_q    <= in_tag;
    end
  end

  // victim lfsr
  always_ff @(posedge clk) begin
    if (rst) begin
      lfsr <= LFSR_SEED;
    end else if (out_load && upd.lfsr_adv) begin
      lfsr <= lfsr_next;
    end
  end

  // output register
  assign set_ext = {8'd0, set_q};

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= {7'd0, tag_q, set_ext[7:0], upd.hit};
    end
  end

  // a word is never accepted while another is being looked up
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    in_fire |=> !s_tready)
    else $error("word accepted during a lookup");

  // a new result only comes out of the compare cycle
  a_result_from_look: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(state == ST_LOOK))
    else $error("result loaded outside the compare cycle");

  // the tag memory is written only in the compare cycle
  a_write_in_look: assert property (@(posedge clk) disable iff (rst)
    mem_wr |-> state == ST_LOOK)
    else $error("tag memory written outside the compare cycle");

  // the victim lfsr never locks up at zero
  a_lfsr_live: assert property (@(posedge clk) disable iff (rst)
    lfsr != 16'h0000)
    else $error("victim lfsr reached zero");

endmodule

FILE: rtl/sacl_addr_split.sv
// sacl_addr_split: splits a byte address into set index and tag
// uses the configured index and offset widths; depends on sacl_pkg
module sacl_addr_split import sacl_pkg::*; #(
  parameter int SET_LOG2 = 8,
  parameter int SET_AW   = 8
) (
  input  logic [ADDR_W-1:0] address,
  input  cfg_t              cfg,
  output logic [SET_AW-1:0] set_idx,
  output logic [TAG_W-1:0]  tag
);

  logic [3:0]        ib;
  logic [5:0]        tag_shift;
  logic [ADDR_W-1:0] shifted;
  logic [SET_AW-1:0] set_mask;

  // clamp index width to the sets that exist
  assign ib = (cfg.index_width > 4'(SET_LOG2)) ? 4'(SET_LOG2) : cfg.index_width;

  // set index: bits above the offset, masked to ib bits
  always_comb begin
    shifted = address >> cfg.offset_width;
    for (int i = 0; i < SET_AW; i++) begin
      set_mask[i] = (4'(i) < ib);
    end
    set_idx = shifted[SET_AW-1:0] & set_mask;
  end

  // tag: bits above index and offset, zero when none are left
  assign tag_shift = {2'b00, ib} + {1'b0, cfg.offset_width};
  assign tag = (tag_shift < 6'(ADDR_W)) ? TAG_W'(address >> tag_shift) : '0;

endmodule

FILE: rtl/sacl_tag_mem.sv
// sacl_tag_mem: one row per set holding the valid bits and tags of all ways
// synchronous memory with registered read and one valid flop per row; depends on sacl_pkg
module sacl_tag_mem import sacl_pkg::*; #(
  parameter int DEPTH  = 256,
  parameter int SET_AW = 8,
  parameter int NWAY   = 8
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        rd_en,
  input  logic [SET_AW-1:0]           rd_addr,
  input  logic                        wr_en,
  input  logic [SET_AW-1:0]           wr_addr,
  input  logic [NWAY-1:0]             wr_vld,
  input  logic [NWAY-1:0][TAG_W-1:0]  wr_tags,
  output logic [NWAY-1:0]             rd_vld,
  output logic [NWAY-1:0][TAG_W-1:0]  rd_tags
);

  localparam int ROW_W = NWAY * (TAG_W + 1);

  logic [ROW_W-1:0]  mem [DEPTH];
  logic [ROW_W-1:0]  rd_row;
  logic [DEPTH-1:0]  row_ok;
  logic              rd_ok;

  // row storage, read data registered
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= {wr_tags, wr_vld};
    end
    if (rd_en) begin
      rd_row <= mem[rd_addr];
    end
  end

  // per-row written flags, a row never written reads as all ways invalid
  always_ff @(posedge clk) begin
    if (rst) begin
      row_ok <= '0;
      rd_ok  <= 1'b0;
    end else begin
      if (wr_en) begin
        row_ok[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_ok <= row_ok[rd_addr];
      end
    end
  end

  assign rd_vld  = rd_ok ? rd_row[NWAY-1:0] : '0;
  assign rd_tags = rd_row[ROW_W-1:NWAY];

endmodule

FILE: rtl/sacl_update.sv
// sacl_update: way compare, hit detection and the new row of a set
// handles lru move-to-newest, age-order insert and random overwrite; depends on sacl_pkg
module sacl_update import sacl_pkg::*; #(
  parameter int WAY_USE = 3,
  parameter int NWAY    = 8
) (
  input  cfg_t                        cfg,
  input  logic                        is_write,
  input  logic [TAG_W-1:0]            tag,
  input  logic [15:0]                 lfsr,
  input  logic [NWAY-1:0]             old_vld,
  input  logic [NWAY-1:0][TAG_W-1:0]  old_tags,
  output logic [NWAY-1:0]             new_vld,
  output logic [NWAY-1:0][TAG_W-1:0]  new_tags,
  output logic [15:0]                 lfsr_next,
  output upd_t                        upd
);

  logic [1:0]                 wl;
  logic [3:0]                 last;
  logic [3:0]                 hp;
  logic [3:0]                 from;
  logic [3:0]                 victim;
  logic                       hit;
  logic                       has_free;
  logic                       alloc;
  logic                       shift;
  logic                       rand_put;
  logic [NWAY:0]              vld_ext;
  logic [NWAY:0][TAG_W-1:0]   tags_ext;

  assign wl = (cfg.ways_log2 > 2'(WAY_USE)) ? 2'(WAY_USE) : cfg.ways_log2;
  assign vld_ext  = {1'b0, old_vld};
  assign tags_ext = {{TAG_W{1'b0}}, old_tags};

  // compare ways in use, newest matching slot wins
  always_comb begin
    last     = (4'd1 << wl) - 4'd1;
    hit      = 1'b0;
    hp       = '0;
    has_free = 1'b0;
    for (int p = 0; p < NWAY; p++) begin
      if (4'(p) <= last) begin
        if (old_vld[p] && old_tags[p] == tag) begin
          hit = 1'b1;
          hp  = 4'(p);
        end
        if (!old_vld[p]) begin
          has_free = 1'b1;
        end
      end
    end
  end

  // replacement decision
  always_comb begin
    alloc     = !(is_write && cfg.write_mode == WM_WT);
    shift     = hit ? (cfg.repl_mode == MODE_LRU)
                    : (alloc && (has_free || !cfg.repl_mode[1]));
    rand_put  = !hit && alloc && !has_free && cfg.repl_mode[1];
    from      = hit ? hp : 4'd0;
    lfsr_next = {1'b0, lfsr[15:1]} ^ (lfsr[0] ? LFSR_TAPS : 16'h0000);
    victim    = {1'b0, lfsr_next[2:0]} & last;
  end

  // new row: shift down toward oldest and insert as newest, or overwrite victim
  always_comb begin
    for (int p = 0; p < NWAY; p++) begin
      new_vld[p]  = old_vld[p];
      new_tags[p] = old_tags[p];
      if (shift) begin
        if (4'(p) == last) begin
          new_vld[p]  = 1'b1;
          new_tags[p] = tag;
        end else if (4'(p) < last && 4'(p) >= from) begin
          new_vld[p]  = vld_ext[p+1];
          new_tags[p] = tags_ext[p+1];
        end
      end else if (rand_put && 4'(p) == victim) begin
        new_vld[p]  = 1'b1;
        new_tags[p] = tag;
      end
    end
  end

  assign upd.hit      = hit;
  assign upd.wr_en    = shift || rand_put;
  assign upd.lfsr_adv = rand_put;

endmodule
